// ===== rtl/fsta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsta_pkg
// Shared widths, register indexes and controller/datapath link types for the
// fixed-step tick accumulator.
// ----------------------------------------------------------------------------
package fsta_pkg;

   // Payload widths
   localparam int ELAPSED_W = 32;
   localparam int PERIOD_W  = 24;
   localparam int SPEED_W   = 16;
   localparam int ADD_W     = ELAPSED_W + SPEED_W;   // scaled time per item
   localparam int ACC_W     = 48;
   localparam int PSCALE_W  = PERIOD_W + 8;          // period in 1/256 us
   localparam int ALPHA_W   = 17;
   localparam int QUOT_W    = 16;
   localparam int TICKS_W   = 32;
   localparam int TOTAL_W   = 64;
   localparam int RUN_W     = 3;

   // Alpha division: one quotient bit per cycle
   localparam int DIV_STEPS = QUOT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_STEP_PERIOD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SPEED       = CSR_IDX_W'(1);

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(16667);
   localparam logic [SPEED_W-1:0]  SPEED_RESET  = SPEED_W'(256);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // take the item, advance the total
      logic mul;      // scale elapsed time by speed
      logic acc;      // saturating add into the accumulator
      logic cmp;      // compare with period, start alpha division
      logic commit;   // update state, load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_done;
   } stat_type;

endpackage : fsta_pkg
`default_nettype wire

// ===== rtl/fsta_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsta channel interfaces
// Valid/ready channels for items in, results out and register writes.
// ----------------------------------------------------------------------------
interface fsta_req_if;
   logic                           valid;
   logic                           ready;
   logic [fsta_pkg::ELAPSED_W-1:0] elapsed_us;

   modport source (output valid, output elapsed_us, input ready);
   modport sink   (input valid, input elapsed_us, output ready);
endinterface : fsta_req_if

interface fsta_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         tick_due;
   logic                         gave_up;
   logic [fsta_pkg::ALPHA_W-1:0] alpha_q16;
   logic [fsta_pkg::TICKS_W-1:0] tick_count;
   logic [fsta_pkg::TOTAL_W-1:0] time_total_us;

   modport source (output valid, output tick_due, output gave_up, output alpha_q16,
                   output tick_count, output time_total_us, input ready);
   modport sink   (input valid, input tick_due, input gave_up, input alpha_q16,
                   input tick_count, input time_total_us, output ready);
endinterface : fsta_rsp_if

interface fsta_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fsta_pkg::CSR_IDX_W-1:0]  index;
   logic [fsta_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : fsta_csr_if
`default_nettype wire

// ===== rtl/fsta_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsta_div
// Restoring divider for alpha: quotient of (acc << 16) / period, one bit per
// cycle. Valid only when acc is below the divisor.
// ----------------------------------------------------------------------------
module fsta_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [fsta_pkg::PSCALE_W-1:0]   dividend,
   input  wire logic [fsta_pkg::PSCALE_W-1:0]   divisor,
   output      logic [fsta_pkg::QUOT_W-1:0]     quotient,
   output      logic                            done
);

   logic [fsta_pkg::PSCALE_W-1:0]  rem_ff, rem_in;
   logic [fsta_pkg::PSCALE_W-1:0]  dsr_ff, dsr_in;
   logic [fsta_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic [fsta_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [fsta_pkg::PSCALE_W:0]    shifted;
   logic [fsta_pkg::PSCALE_W:0]    diff;

   // One trial subtract per cycle
   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsr_in  = divisor;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[fsta_pkg::PSCALE_W]) begin
            rem_in  = diff[fsta_pkg::PSCALE_W-1:0];
            quot_in = {quot_ff[fsta_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[fsta_pkg::PSCALE_W-1:0];
            quot_in = {quot_ff[fsta_pkg::QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fsta_pkg::DIV_CNT_W'(fsta_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule : fsta_div
`default_nettype wire

// ===== rtl/fsta_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsta_ctrl
// Sequencer: accepts one item, steps the datapath through multiply,
// accumulate, compare and divide, then commits into the result register.
// ----------------------------------------------------------------------------
module fsta_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      fsta_pkg::cmd_type  cmd,
   input  wire fsta_pkg::stat_type stat
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_UPD  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // Result register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : fsta_ctrl
`default_nettype wire

// ===== rtl/fsta_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsta_dpath
// Configuration registers, accumulator state, speed multiplier, alpha divider
// and the result register.
// ----------------------------------------------------------------------------
module fsta_dpath #(
   parameter int CATCHUP_LIMIT = 3
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire fsta_pkg::cmd_type                 cmd,
   output      fsta_pkg::stat_type                stat,
   input  wire logic                              csr_we,
   input  wire logic [fsta_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fsta_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic [fsta_pkg::ELAPSED_W-1:0]    elapsed_us,
   output      logic                              tick_due,
   output      logic                              gave_up,
   output      logic [fsta_pkg::ALPHA_W-1:0]      alpha_q16,
   output      logic [fsta_pkg::TICKS_W-1:0]      tick_count,
   output      logic [fsta_pkg::TOTAL_W-1:0]      time_total_us
);

   localparam int RUN_INC_W = fsta_pkg::RUN_W + 1;

   logic [fsta_pkg::PERIOD_W-1:0]  period_ff;
   logic [fsta_pkg::SPEED_W-1:0]   speed_ff;
   logic [fsta_pkg::ELAPSED_W-1:0] elapsed_ff;
   logic [fsta_pkg::ADD_W-1:0]     add_ff;
   logic [fsta_pkg::ACC_W-1:0]     accum_ff, accum_in;
   logic [fsta_pkg::RUN_W-1:0]     run_ff, run_in;
   logic [fsta_pkg::TICKS_W-1:0]   steps_ff, steps_in;
   logic [fsta_pkg::TOTAL_W-1:0]   total_ff;
   logic                           ge_ff;
   logic                           due_ff, due_in;
   logic                           gave_ff, gave_in;
   logic [fsta_pkg::ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [fsta_pkg::TICKS_W-1:0]   ticks_out_ff;
   logic [fsta_pkg::TOTAL_W-1:0]   total_out_ff;

   logic [fsta_pkg::PSCALE_W-1:0]  period_scaled;
   logic [fsta_pkg::ACC_W:0]       acc_sum;
   logic [RUN_INC_W-1:0]           run_inc;
   logic [fsta_pkg::QUOT_W-1:0]    quotient;
   logic                           div_done;

   assign period_scaled = {period_ff, 8'd0};

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= fsta_pkg::PERIOD_RESET;
         speed_ff  <= fsta_pkg::SPEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            fsta_pkg::REG_STEP_PERIOD: period_ff <= csr_data[fsta_pkg::PERIOD_W-1:0];
            fsta_pkg::REG_SPEED:       speed_ff  <= csr_data[fsta_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the item and advance the running total
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.load) begin
         total_ff <= total_ff + {{(fsta_pkg::TOTAL_W-fsta_pkg::ELAPSED_W){1'b0}}, elapsed_us};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         elapsed_ff <= elapsed_us;
      end
      if (cmd.mul) begin
         add_ff <= {{fsta_pkg::SPEED_W{1'b0}}, elapsed_ff} *
                   {{fsta_pkg::ELAPSED_W{1'b0}}, speed_ff};
      end
      if (cmd.cmp) begin
         ge_ff <= (accum_ff >= {{(fsta_pkg::ACC_W-fsta_pkg::PSCALE_W){1'b0}}, period_scaled});
      end
   end

   // Alpha division, started on compare
   fsta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.cmp),
      .dividend (accum_ff[fsta_pkg::PSCALE_W-1:0]),
      .divisor  (period_scaled),
      .quotient (quotient),
      .done     (div_done)
   );

   assign stat.div_done = div_done;

   assign acc_sum = {1'b0, accum_ff} + {{(fsta_pkg::ACC_W+1-fsta_pkg::ADD_W){1'b0}}, add_ff};
   assign run_inc = {1'b0, run_ff} + 1'b1;

   // Accumulate with saturation, then settle the step on commit
   always_comb begin
      accum_in = accum_ff;
      run_in   = run_ff;
      steps_in = steps_ff;
      due_in   = 1'b0;
      gave_in  = 1'b0;
      alpha_in = ge_ff ? fsta_pkg::ALPHA_ONE : {1'b0, quotient};
      if (cmd.acc) begin
         accum_in = acc_sum[fsta_pkg::ACC_W] ? '1 : acc_sum[fsta_pkg::ACC_W-1:0];
      end else if (cmd.commit) begin
         if (ge_ff) begin
            steps_in = steps_ff + 1'b1;
            if (run_inc > RUN_INC_W'(CATCHUP_LIMIT)) begin
               // Too far behind: drop the backlog
               run_in   = '0;
               accum_in = '0;
               gave_in  = 1'b1;
            end else begin
               run_in   = run_inc[fsta_pkg::RUN_W-1:0];
               accum_in = accum_ff -
                  {{(fsta_pkg::ACC_W-fsta_pkg::PSCALE_W){1'b0}}, period_scaled};
               due_in   = 1'b1;
            end
         end else begin
            run_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         run_ff   <= '0;
         steps_ff <= '0;
      end else begin
         accum_ff <= accum_in;
         run_ff   <= run_in;
         steps_ff <= steps_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         due_ff       <= due_in;
         gave_ff      <= gave_in;
         alpha_ff     <= alpha_in;
         ticks_out_ff <= steps_in;
         total_out_ff <= total_ff;
      end
   end

   assign tick_due      = due_ff;
   assign gave_up       = gave_ff;
   assign alpha_q16     = alpha_ff;
   assign tick_count    = ticks_out_ff;
   assign time_total_us = total_out_ff;

endmodule : fsta_dpath
`default_nettype wire

// ===== rtl/fixed_step_tick_accumulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_step_tick_accumulator
// Fixed-timestep accumulator: totals elapsed time, scales it into a
// saturating accumulator, reports tick due, give-up and interpolation alpha.
// ----------------------------------------------------------------------------
//   channel  direction  payload
//   req_ch   in         elapsed_us
//   rsp_ch   out        tick_due, gave_up, alpha_q16, tick_count, time_total_us
//   csr_ch   in         index, data (0: step_period_us, 1: speed_q8)
//
// One item passes from accept to result through multiply, accumulate,
// compare, 16 steps of the bit-serial alpha divider, its registered done
// flag and commit. A new item is accepted only once the last one is committed.
// The result register holds an item until taken; a stalled result holds the
// commit, and the next item is accepted once the sequencer returns to idle.
// Register writes are taken every cycle. Synchronous reset restores the
// register defaults and clears the accumulator, run, tick count and total.
// ----------------------------------------------------------------------------
module fixed_step_tick_accumulator #(
   parameter int CATCHUP_LIMIT = 3
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fsta_req_if.sink   req_ch,
   fsta_rsp_if.source rsp_ch,
   fsta_csr_if.sink   csr_ch
);

   fsta_pkg::cmd_type  cmd;
   fsta_pkg::stat_type stat;

   assign csr_ch.ready = 1'b1;

   // Sequencer
   fsta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Arithmetic and state
   fsta_dpath #(
      .CATCHUP_LIMIT (CATCHUP_LIMIT)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_we        (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .elapsed_us    (req_ch.elapsed_us),
      .tick_due      (rsp_ch.tick_due),
      .gave_up       (rsp_ch.gave_up),
      .alpha_q16     (rsp_ch.alpha_q16),
      .tick_count    (rsp_ch.tick_count),
      .time_total_us (rsp_ch.time_total_us)
   );

endmodule : fixed_step_tick_accumulator
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed-step tick accumulator. A behavioral
// timer model predicts tick, give-up, alpha, tick count and time total for
// every elapsed-time item; results are checked in order, field by field,
// under random stalls on both channels and several period/speed settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int          CATCH_LIMIT  = 3;
   localparam int          DRAIN_CYCLES = 30;
   localparam int          WATCHDOG     = 2000;
   localparam int          HOLD_CYCLES  = 150;
   localparam int          PHASE_ITEMS  = 147;
   localparam logic [63:0] ACC_FULL     = (64'd1 << fsta_pkg::ACC_W) - 64'd1;
   localparam logic [31:0] ELAPSED_MAX  = 32'hFFFF_FFFF;

   // Indexes that decode to no register
   localparam logic [fsta_pkg::CSR_IDX_W-1:0] REG_NONE_LO = fsta_pkg::CSR_IDX_W'(2);
   localparam logic [fsta_pkg::CSR_IDX_W-1:0] REG_NONE_HI = fsta_pkg::CSR_IDX_W'(15);

   typedef struct packed {
      logic                         tick_due;
      logic                         gave_up;
      logic [fsta_pkg::ALPHA_W-1:0] alpha_q16;
      logic [fsta_pkg::TICKS_W-1:0] tick_count;
      logic [fsta_pkg::TOTAL_W-1:0] time_total_us;
   } tick_result_type;

   logic clock;
   logic reset;

   fsta_req_if req_ch ();
   fsta_rsp_if rsp_ch ();
   fsta_csr_if csr_ch ();

   fixed_step_tick_accumulator #(
      .CATCHUP_LIMIT(CATCH_LIMIT)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Timer model state and its copy of the registers
   logic [fsta_pkg::PERIOD_W-1:0] m_period;
   logic [fsta_pkg::SPEED_W-1:0]  m_speed;
   logic [fsta_pkg::ACC_W-1:0]    m_acc   = '0;
   logic [fsta_pkg::RUN_W-1:0]    m_run   = '0;
   logic [fsta_pkg::TICKS_W-1:0]  m_ticks = '0;
   logic [fsta_pkg::TOTAL_W-1:0]  m_total = '0;

   logic [fsta_pkg::ELAPSED_W-1:0] pending_elapsed[$];
   tick_result_type                expected_ticks[$];

   bit calm;
   int req_taken;       // items accepted, counted by the monitor
   int req_done;        // acceptances already handled by the sender
   int rsp_hold_asks;   // long hold-offs requested by the stimulus
   int rsp_hold_given;  // long hold-offs started by the receiver
   int req_gap;
   int rsp_gap;
   int rsp_hold_left;
   int mismatches;
   int results_seen;
   int idle_cycles;

   // Advance the timer model by one elapsed-time item
   function automatic tick_result_type step_timer(
      input logic [fsta_pkg::ELAPSED_W-1:0] elapsed);
      logic [63:0]              scaled;
      logic [63:0]              pscaled;
      logic [63:0]              frac;
      logic [fsta_pkg::RUN_W:0] run;
      tick_result_type          r;
      r       = '0;
      pscaled = 64'(m_period) << 8;
      scaled  = 64'(elapsed) * 64'(m_speed);
      m_total = m_total + 64'(elapsed);
      if (scaled > ACC_FULL - 64'(m_acc)) begin
         m_acc = ACC_FULL[fsta_pkg::ACC_W-1:0];
      end else begin
         m_acc = m_acc + scaled[fsta_pkg::ACC_W-1:0];
      end
      // Alpha from the accumulator before any subtraction
      if (pscaled == 64'd0 || 64'(m_acc) >= pscaled) begin
         r.alpha_q16 = fsta_pkg::ALPHA_ONE;
      end else begin
         frac        = (64'(m_acc) << 16) / pscaled;
         r.alpha_q16 = frac[fsta_pkg::ALPHA_W-1:0];
      end
      if (64'(m_acc) >= pscaled) begin
         m_acc   = m_acc - pscaled[fsta_pkg::ACC_W-1:0];
         run     = {1'b0, m_run} + 1'b1;
         m_ticks = m_ticks + 1'b1;
         if (run > CATCH_LIMIT) begin
            m_run     = '0;
            m_acc     = '0;
            r.gave_up = 1'b1;
         end else begin
            m_run      = run[fsta_pkg::RUN_W-1:0];
            r.tick_due = 1'b1;
         end
      end else begin
         m_run = '0;
      end
      r.tick_count    = m_ticks;
      r.time_total_us = m_total;
      return r;
   endfunction

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s at result %0d: expected %0h, got %0h",
                  field, results_seen, want, got);
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sender: hold an offered item until taken, idle in short bursts
   always @(negedge clock) begin
      logic                           nxt_valid;
      logic [fsta_pkg::ELAPSED_W-1:0] nxt_data;
      nxt_valid = req_ch.valid;
      nxt_data  = req_ch.elapsed_us;
      if (req_ch.valid !== 1'b1 || req_done != req_taken) begin
         req_done  = req_taken;
         nxt_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_elapsed.size() > 0) begin
            if (!calm && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 4) - 1;
            end else begin
               nxt_valid = 1'b1;
               nxt_data  = pending_elapsed.pop_front();
            end
         end
      end
      req_ch.valid      <= nxt_valid;
      req_ch.elapsed_us <= nxt_data;
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   always @(negedge clock) begin
      logic rdy;
      if (rsp_hold_given != rsp_hold_asks) begin
         rsp_hold_given = rsp_hold_asks;
         rsp_hold_left  = HOLD_CYCLES;
      end
      rdy = 1'b1;
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rdy = 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_gap = $urandom_range(1, 4) - 1;
         rdy     = 1'b0;
      end
      rsp_ch.ready <= rdy;
   end

   // Monitor: predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      bit              fired;
      fired = csr_ch.valid && csr_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
         expected_ticks.push_back(step_timer(req_ch.elapsed_us));
         req_taken++;
         fired = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
         fired = 1'b1;
         got.tick_due      = rsp_ch.tick_due;
         got.gave_up       = rsp_ch.gave_up;
         got.alpha_q16     = rsp_ch.alpha_q16;
         got.tick_count    = rsp_ch.tick_count;
         got.time_total_us = rsp_ch.time_total_us;
         if (expected_ticks.size() == 0) begin
            note_mismatch("spurious result", 64'd0, 64'(got.tick_count));
         end else begin
            want = expected_ticks.pop_front();
            if (got.tick_due !== want.tick_due)
               note_mismatch("tick_due", 64'(want.tick_due), 64'(got.tick_due));
            if (got.gave_up !== want.gave_up)
               note_mismatch("gave_up", 64'(want.gave_up), 64'(got.gave_up));
            if (got.alpha_q16 !== want.alpha_q16)
               note_mismatch("alpha_q16", 64'(want.alpha_q16), 64'(got.alpha_q16));
            if (got.tick_count !== want.tick_count)
               note_mismatch("tick_count", 64'(want.tick_count), 64'(got.tick_count));
            if (got.time_total_us !== want.time_total_us)
               note_mismatch("time_total_us", want.time_total_us, got.time_total_us);
         end
         results_seen++;
      end
      // Watchdog on stretches with no handshake at all
      if (fired) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Write one register and mirror it into the model once taken
   task automatic csr_write(input logic [fsta_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fsta_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!(csr_ch.valid && csr_ch.ready)) @(posedge clock);
      if (idx == fsta_pkg::REG_STEP_PERIOD) begin
         m_period = value[fsta_pkg::PERIOD_W-1:0];
      end else if (idx == fsta_pkg::REG_SPEED) begin
         m_speed = value[fsta_pkg::SPEED_W-1:0];
      end
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_timing(input logic [fsta_pkg::PERIOD_W-1:0] period,
                             input logic [fsta_pkg::SPEED_W-1:0] speed);
      csr_write(fsta_pkg::REG_STEP_PERIOD, fsta_pkg::CSR_DATA_W'(period));
      csr_write(fsta_pkg::REG_SPEED, fsta_pkg::CSR_DATA_W'(speed));
      csr_release();
   endtask

   // Wait until every item is taken and every result checked
   task automatic drain();
      while (pending_elapsed.size() != 0 || expected_ticks.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Elapsed time drawn around one scaled period, with bursts that force catch-up
   function automatic logic [fsta_pkg::ELAPSED_W-1:0] pick_elapsed();
      logic [63:0] span;
      logic [63:0] pick;
      int          sel;
      span = (m_speed == '0) ? 64'(m_period) : (64'(m_period) << 8) / 64'(m_speed);
      if (span == 64'd0) span = 64'd1;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         pick = {$urandom, $urandom} % (2 * span + 1);
      end else if (sel < 65) begin
         pick = {$urandom, $urandom} % (span / 4 + 1);
      end else if (sel < 80) begin
         pick = span * $urandom_range(2, 6) + {$urandom, $urandom} % (span / 2 + 1);
      end else if (sel < 95) begin
         pick = 64'($urandom);
      end else begin
         pick = $urandom_range(0, 1) ? 64'(ELAPSED_MAX) : 64'd0;
      end
      if (pick > 64'(ELAPSED_MAX)) pick = 64'(ELAPSED_MAX);
      return pick[fsta_pkg::ELAPSED_W-1:0];
   endfunction

   task automatic run_random(input int count);
      repeat (count) pending_elapsed.push_back(pick_elapsed());
      drain();
   endtask

   task automatic run_list(input logic [fsta_pkg::ELAPSED_W-1:0] list[]);
      foreach (list[i]) pending_elapsed.push_back(list[i]);
      drain();
   endtask

   // Stimulus
   initial begin
      reset        = 1'b1;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data  <= '0;
      m_period     = fsta_pkg::PERIOD_RESET;
      m_speed      = fsta_pkg::SPEED_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset defaults: boundary around one period, then a huge gap that
      // runs the catch-up count past its limit
      run_list('{32'd0, 32'd16666, 32'd1, 32'd16667, ELAPSED_MAX, 32'd0, 32'd0, 32'd0});

      // Fastest speed, shortest nonzero period: saturate the accumulator
      set_timing(fsta_pkg::PERIOD_W'(1), fsta_pkg::SPEED_W'(16'hFFFF));
      run_list('{ELAPSED_MAX, ELAPSED_MAX, 32'h1234_5678, 32'd0});

      // Zero period: every item reaches a tick, due or, past the catch-up limit, give-up
      set_timing(fsta_pkg::PERIOD_W'(0), fsta_pkg::SPEED_W'(256));
      run_list('{32'd0, 32'hAAAA_AAAA, 32'h5555_5555, 32'd7, 32'd0});

      // Zero speed: accumulator frozen, total still advances
      set_timing(fsta_pkg::PERIOD_W'(24'hFFFFFF), fsta_pkg::SPEED_W'(0));
      run_list('{ELAPSED_MAX, 32'd7});

      // Writes to unused indexes are dropped; upper speed data bits ignored
      csr_write(REG_NONE_LO, fsta_pkg::CSR_DATA_W'(24'hFFFFFF));
      csr_write(REG_NONE_HI, fsta_pkg::CSR_DATA_W'(0));
      csr_write(fsta_pkg::REG_SPEED, fsta_pkg::CSR_DATA_W'(24'hFF0100));
      csr_release();
      run_list('{32'd100000, 32'hFFFF_0000, 32'd3});

      // Random phases; the first one holds results back for a long stretch
      set_timing(fsta_pkg::PERIOD_W'(16667), fsta_pkg::SPEED_W'(256));
      rsp_hold_asks++;
      run_random(PHASE_ITEMS);
      set_timing(fsta_pkg::PERIOD_W'(1000), fsta_pkg::SPEED_W'(512));
      run_random(PHASE_ITEMS);
      set_timing(fsta_pkg::PERIOD_W'(1), fsta_pkg::SPEED_W'(16'hFFFF));
      run_random(PHASE_ITEMS);
      set_timing(fsta_pkg::PERIOD_W'($urandom_range(1, 4095)),
                 fsta_pkg::SPEED_W'($urandom_range(1, 65535)));
      run_random(PHASE_ITEMS);
      set_timing(fsta_pkg::PERIOD_W'(24'hFFFFFF), fsta_pkg::SPEED_W'(16'hFFFF));
      run_random(PHASE_ITEMS);
      set_timing(fsta_pkg::PERIOD_W'(0), fsta_pkg::SPEED_W'($urandom_range(0, 65535)));
      run_random(PHASE_ITEMS);
      set_timing(fsta_pkg::PERIOD_W'($urandom_range(1, 24'hFFFFFF)),
                 fsta_pkg::SPEED_W'($urandom));
      run_random(PHASE_ITEMS);

      // Closing phase at full rate, no stalls on either side
      set_timing(fsta_pkg::PERIOD_W'(250), fsta_pkg::SPEED_W'(128));
      calm = 1'b1;
      run_random(PHASE_ITEMS);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule : tb
